// File: design/evr_pkg.sv
package evr_pkg;

  localparam int CoordW   = 32;
  localparam int TurnW    = 16;
  localparam int TrigFrac = 15;
  localparam int TrigW    = TrigFrac + 2;   // signed, +-1.0 exact
  localparam int TabW     = TrigFrac + 1;   // unsigned table entries, 0..1.0
  localparam int TabLast  = 1000;           // eighth turn
  localparam int KW       = 10;
  localparam int ProdW    = CoordW + TrigW;
  localparam int SumW     = ProdW + 1;
  localparam int Stages   = 9;

  localparam logic [63:0] PiQ60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] OneQ60  = 64'h1000000000000000;
  localparam logic [63:0] StepQ60 = PiQ60 / 64'd4000;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } evr_quad_e;

  typedef struct packed {
    logic signed [CoordW-1:0] vec_x;
    logic signed [CoordW-1:0] vec_y;
    logic signed [CoordW-1:0] vec_z;
    logic signed [TurnW-1:0]  turn_x;
    logic signed [TurnW-1:0]  turn_y;
    logic signed [TurnW-1:0]  turn_z;
  } evr_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
  } evr_out_t;

  typedef struct packed {
    logic [KW-1:0] k;
    logic          swap;
    evr_quad_e     quad;
  } evr_angle_t;

  typedef struct packed {
    logic signed [TrigW-1:0] s;
    logic signed [TrigW-1:0] c;
  } evr_trig_t;

  typedef logic [TabW-1:0] evr_tab_t [0:TabLast];

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // restoring long division, only used while building the tables
  function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series at Q4.60, rounded to nearest at TrigFrac bits
  function automatic logic [TabW-1:0] fold_trig(int k, bit want_cos);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] rnd;
    x = 64'(k) * StepQ60;
    x2 = mul_q60(x, x);
    term = want_cos ? OneQ60 : x;
    sum = term;
    for (int i = 0; i < 10; i++) begin
      den = want_cos ? 64'((2 * i + 1) * (2 * i + 2)) : 64'((2 * i + 2) * (2 * i + 3));
      term = div_u64(mul_q60(term, x2), den);
      if ((i % 2) == 0) sum = sum - term;
      else sum = sum + term;
    end
    rnd = (sum + (64'd1 << (60 - TrigFrac - 1))) >> (60 - TrigFrac);
    return rnd[TabW-1:0];
  endfunction

  function automatic evr_tab_t build_tab(bit want_cos);
    evr_tab_t t;
    for (int k = 0; k <= TabLast; k++) t[k] = fold_trig(k, want_cos);
    return t;
  endfunction

  localparam evr_tab_t SinTab = build_tab(1'b0);
  localparam evr_tab_t CosTab = build_tab(1'b1);

  // amount mod 8000, then quadrant and fold into 0..eighth turn
  function automatic evr_angle_t fold_angle(logic signed [TurnW-1:0] t);
    logic [16:0] u;
    logic [10:0] r;
    evr_angle_t a;
    u = 17'({t[TurnW-1], t} + 17'sd40000);
    if (u >= 17'd64000) u = u - 17'd64000;
    if (u >= 17'd32000) u = u - 17'd32000;
    if (u >= 17'd16000) u = u - 17'd16000;
    if (u >= 17'd8000)  u = u - 17'd8000;
    if (u >= 17'd6000) begin
      a.quad = QUAD_3;
      r = 11'(u - 17'd6000);
    end else if (u >= 17'd4000) begin
      a.quad = QUAD_2;
      r = 11'(u - 17'd4000);
    end else if (u >= 17'd2000) begin
      a.quad = QUAD_1;
      r = 11'(u - 17'd2000);
    end else begin
      a.quad = QUAD_0;
      r = u[10:0];
    end
    a.swap = (r > 11'd1000);
    a.k = a.swap ? KW'(11'd2000 - r) : r[KW-1:0];
    return a;
  endfunction

endpackage

// File: design/evr_trig_rom.sv
module evr_trig_rom (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [evr_pkg::KW-1:0] k_i,
  output logic [evr_pkg::TabW-1:0] sin_o,
  output logic [evr_pkg::TabW-1:0] cos_o
);
  import evr_pkg::*;

  logic [TabW-1:0] sin_q;
  logic [TabW-1:0] cos_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= SinTab[k_i];
      cos_q <= CosTab[k_i];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule

// File: design/evr_plane.sv
module evr_plane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [evr_pkg::CoordW-1:0] a_i,
  input  logic signed [evr_pkg::CoordW-1:0] b_i,
  input  evr_pkg::evr_trig_t                trig_i,
  output logic signed [evr_pkg::CoordW-1:0] a_o,
  output logic signed [evr_pkg::CoordW-1:0] b_o
);
  import evr_pkg::*;

  localparam int RndW = SumW - TrigFrac;
  localparam logic signed [RndW-1:0] MaxV = RndW'({1'b0, {(CoordW-1){1'b1}}});
  localparam logic signed [RndW-1:0] MinV = -MaxV - RndW'(1);

  logic signed [ProdW-1:0] ac_q, bs_q, as_q, bc_q;
  logic signed [SumW-1:0]  na_sum, nb_sum;
  logic signed [CoordW-1:0] a_d, b_d, a_q, b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q <= ProdW'(a_i) * ProdW'(trig_i.c);
      bs_q <= ProdW'(b_i) * ProdW'(trig_i.s);
      as_q <= ProdW'(a_i) * ProdW'(trig_i.s);
      bc_q <= ProdW'(b_i) * ProdW'(trig_i.c);
    end
  end

  function automatic logic signed [CoordW-1:0] finish(logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] w;
    logic signed [RndW-1:0] r;
    w = v + SumW'(1 << (TrigFrac - 1));
    r = RndW'(w >>> TrigFrac);
    if (r > MaxV) return MaxV[CoordW-1:0];
    if (r < MinV) return MinV[CoordW-1:0];
    return r[CoordW-1:0];
  endfunction

  always_comb begin
    na_sum = SumW'(ac_q) - SumW'(bs_q);
    nb_sum = SumW'(as_q) + SumW'(bc_q);
    a_d = finish(na_sum);
    b_d = finish(nb_sum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
endmodule

// File: design/euler_vector_rotator.sv
// Pipeline: angle fold, ROM read, trig fixup, then planes xy, yz, zx, each with a product and a rounded register.
// Throughput: one beat per cycle; the whole pipe holds while the output beat
// is stalled, so in_stall_o follows out_valid_o && out_stall_i.
// Trig lookup is a registered read of 1001-entry sine and cosine ROMs.
// Reset (rst_ni low, async) clears all valid bits; data regs are not reset.
module euler_vector_rotator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  evr_pkg::evr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output evr_pkg::evr_out_t out_data_o
);
  import evr_pkg::*;

  logic [Stages-1:0] v_q;
  logic              adv;

  assign adv = !(v_q[Stages-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Stages-2:0], in_valid_i};
    end
  end

  // index 0: turn_z (xy), 1: turn_y (yz), 2: turn_x (zx)
  evr_angle_t ang1_q [3];
  evr_angle_t ang2_q [3];
  logic signed [CoordW-1:0] x1_q, y1_q, z1_q, x2_q, y2_q, z2_q, x3_q, y3_q, z3_q;
  logic [TabW-1:0] sin_w [3];
  logic [TabW-1:0] cos_w [3];
  evr_trig_t trig3_q [3];
  evr_trig_t trig_d [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang1_q[0] <= fold_angle(in_data_i.turn_z);
      ang1_q[1] <= fold_angle(in_data_i.turn_y);
      ang1_q[2] <= fold_angle(in_data_i.turn_x);
      x1_q <= in_data_i.vec_x;
      y1_q <= in_data_i.vec_y;
      z1_q <= in_data_i.vec_z;
      ang2_q <= ang1_q;
      x2_q <= x1_q;
      y2_q <= y1_q;
      z2_q <= z1_q;
      trig3_q <= trig_d;
      x3_q <= x2_q;
      y3_q <= y2_q;
      z3_q <= z2_q;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_trig
    logic signed [TrigW-1:0] s0, c0;
    evr_trig_rom u_rom (
      .clk_i (clk_i),
      .en_i  (adv),
      .k_i   (ang1_q[g].k),
      .sin_o (sin_w[g]),
      .cos_o (cos_w[g])
    );
    always_comb begin
      if (ang2_q[g].swap) begin
        s0 = TrigW'({1'b0, cos_w[g]});
        c0 = TrigW'({1'b0, sin_w[g]});
      end else begin
        s0 = TrigW'({1'b0, sin_w[g]});
        c0 = TrigW'({1'b0, cos_w[g]});
      end
      case (ang2_q[g].quad)
        QUAD_0: begin trig_d[g].s = s0;  trig_d[g].c = c0;  end
        QUAD_1: begin trig_d[g].s = c0;  trig_d[g].c = -s0; end
        QUAD_2: begin trig_d[g].s = -s0; trig_d[g].c = -c0; end
        default: begin trig_d[g].s = -c0; trig_d[g].c = s0; end
      endcase
    end
  end

  // plane 1: xy by turn_z
  logic signed [CoordW-1:0] x5, y5, z4_q, z5_q;
  evr_trig_t ty4_q, ty5_q, tx4_q, tx5_q;

  evr_plane u_p1 (
    .clk_i (clk_i), .en_i (adv),
    .a_i (x3_q), .b_i (y3_q), .trig_i (trig3_q[0]),
    .a_o (x5), .b_o (y5)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      z4_q  <= z3_q;
      z5_q  <= z4_q;
      ty4_q <= trig3_q[1];
      ty5_q <= ty4_q;
      tx4_q <= trig3_q[2];
      tx5_q <= tx4_q;
    end
  end

  // plane 2: yz by turn_y
  logic signed [CoordW-1:0] y7, z7, x6_q, x7_q;
  evr_trig_t tx6_q, tx7_q;

  evr_plane u_p2 (
    .clk_i (clk_i), .en_i (adv),
    .a_i (y5), .b_i (z5_q), .trig_i (ty5_q),
    .a_o (y7), .b_o (z7)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x6_q  <= x5;
      x7_q  <= x6_q;
      tx6_q <= tx5_q;
      tx7_q <= tx6_q;
    end
  end

  // plane 3: zx by turn_x
  logic signed [CoordW-1:0] z9, x9, y8_q, y9_q;

  evr_plane u_p3 (
    .clk_i (clk_i), .en_i (adv),
    .a_i (z7), .b_i (x7_q), .trig_i (tx7_q),
    .a_o (z9), .b_o (x9)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y8_q <= y7;
      y9_q <= y8_q;
    end
  end

  assign out_valid_o = v_q[Stages-1];
  assign out_data_o.out_x = x9;
  assign out_data_o.out_y = y9_q;
  assign out_data_o.out_z = z9;
endmodule

// File: design/evr_checker.sv
module evr_sva (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input evr_pkg::evr_out_t out_data_o
);
  import evr_pkg::*;

  // the pipe holds only when the output beat is blocked
  a_stall_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("in_stall_o does not follow output backpressure");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // an empty input slot carried through the pipe with no stall on the way means no output beat then
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_i && !in_stall_o ##1 !in_stall_o ##1 !in_stall_o ##1 !in_stall_o
    ##1 !in_stall_o ##1 !in_stall_o ##1 !in_stall_o ##1 !in_stall_o
    ##1 !in_stall_o |=> !out_valid_o)
    else $error("output beat without matching input beat");
endmodule

bind euler_vector_rotator evr_sva u_evr_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
